>>> design/round_robin_run_and_timed_pause_queue_defines.svh
// Assertion macros for the round-robin run and timed pause queue.
`ifndef ROUND_ROBIN_RUN_AND_TIMED_PAUSE_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_RUN_AND_TIMED_PAUSE_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RRTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrtq assertion failed");

// Next-cycle implication, disabled in reset
`define RRTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrtq assertion failed");

`endif

>>> design/rrtq_pkg.sv
// Package: constants, codes and controller/datapath interface types.
`default_nettype none
package rrtq_pkg;

    localparam int RUN_DEPTH   = 64;
    localparam int PAUSE_DEPTH = 64;
    localparam int RUN_AW      = $clog2(RUN_DEPTH);
    localparam int PAUSE_AW    = $clog2(PAUSE_DEPTH);
    localparam int RUN_CW      = $clog2(RUN_DEPTH + 1);
    localparam int PAUSE_CW    = $clog2(PAUSE_DEPTH + 1);
    localparam int IDX_W       = (RUN_CW > PAUSE_CW) ? RUN_CW : PAUSE_CW;
    localparam int COUNT_W     = 7;

    // action codes
    localparam logic [2:0] ACT_ENQUEUE = 3'd0;
    localparam logic [2:0] ACT_DEQUEUE = 3'd1;
    localparam logic [2:0] ACT_PAUSE   = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_PICK    = 3'd4;
    localparam logic [2:0] ACT_RETIRE  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_RSRCH_RD, S_RSRCH_CMP, S_RDROP_RD, S_RDROP_WR, S_AFTER_DROP,
        S_PSRCH_RD, S_PSRCH_CMP, S_PSHIFT_RD, S_PSHIFT_WR,
        S_QSRCH_RD, S_QSRCH_CMP, S_QDROP_RD, S_QDROP_WR,
        S_PICK_FIN, S_MOD, S_RET_CMP, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_APPEND, OP_SET_NF, OP_SET_FULL,
        OP_RUN_RD_K, OP_RUN_RD_K1, OP_RUN_WR_K, OP_K_INC, OP_K_CLR, OP_RUN_FIN,
        OP_PS_RD_K, OP_PS_RD_K1, OP_PS_RD_KM1, OP_PS_WR_K_INC, OP_PS_WR_K_DEC,
        OP_POS_K, OP_PS_INS, OP_PS_FIN,
        OP_PICK_RD, OP_PICK_FIN, OP_IDLE_PICK,
        OP_MOD_LOAD, OP_MOD_SUB, OP_RUN_RD_M, OP_K_FROM_M, OP_OUT
    } dp_op_t;

    typedef struct packed {
        logic [2:0] act;
        logic       leave;
        logic       run_empty;
        logic       pause_full;
        logic       lpv;
        logic       k_lt_run;
        logic       k1_lt_run;
        logic       k_lt_pause;
        logic       k1_lt_pause;
        logic       k_gt_pos;
        logic       run_match;
        logic       pause_id_match;
        logic       pause_time_gt;
        logic       mod_ge;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

>>> design/rrtq_ctrl.sv
// Controller: sequencer state machine issuing datapath micro-operations.
`default_nettype none
module rrtq_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  rrtq_pkg::dp_status_t st,
    output rrtq_pkg::dp_op_t    op
);

    rrtq_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrtq_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrtq_pkg::S_IDLE:
                if (in_valid) state_next = rrtq_pkg::S_DISPATCH;
            rrtq_pkg::S_DISPATCH:
            begin
                unique case (st.act)
                    rrtq_pkg::ACT_DEQUEUE, rrtq_pkg::ACT_PAUSE:
                        state_next = rrtq_pkg::S_RSRCH_RD;
                    rrtq_pkg::ACT_RESTART:
                        state_next = rrtq_pkg::S_QSRCH_RD;
                    rrtq_pkg::ACT_PICK:
                        state_next = st.run_empty ? rrtq_pkg::S_DONE : rrtq_pkg::S_PICK_FIN;
                    rrtq_pkg::ACT_RETIRE:
                        state_next = (st.run_empty || !st.lpv) ? rrtq_pkg::S_DONE
                                                                : rrtq_pkg::S_MOD;
                    default:
                        state_next = rrtq_pkg::S_DONE;
                endcase
            end
            rrtq_pkg::S_RSRCH_RD:
                state_next = st.k_lt_run ? rrtq_pkg::S_RSRCH_CMP : rrtq_pkg::S_DONE;
            rrtq_pkg::S_RSRCH_CMP:
                state_next = st.run_match ? rrtq_pkg::S_RDROP_RD : rrtq_pkg::S_RSRCH_RD;
            rrtq_pkg::S_RDROP_RD:
                state_next = st.k1_lt_run ? rrtq_pkg::S_RDROP_WR : rrtq_pkg::S_AFTER_DROP;
            rrtq_pkg::S_RDROP_WR:
                state_next = rrtq_pkg::S_RDROP_RD;
            rrtq_pkg::S_AFTER_DROP:
                state_next = (st.act == rrtq_pkg::ACT_PAUSE && !st.pause_full)
                             ? rrtq_pkg::S_PSRCH_RD : rrtq_pkg::S_DONE;
            rrtq_pkg::S_PSRCH_RD:
                state_next = st.k_lt_pause ? rrtq_pkg::S_PSRCH_CMP : rrtq_pkg::S_PSHIFT_RD;
            rrtq_pkg::S_PSRCH_CMP:
                state_next = st.pause_time_gt ? rrtq_pkg::S_PSHIFT_RD : rrtq_pkg::S_PSRCH_RD;
            rrtq_pkg::S_PSHIFT_RD:
                state_next = st.k_gt_pos ? rrtq_pkg::S_PSHIFT_WR : rrtq_pkg::S_DONE;
            rrtq_pkg::S_PSHIFT_WR:
                state_next = rrtq_pkg::S_PSHIFT_RD;
            rrtq_pkg::S_QSRCH_RD:
                state_next = st.k_lt_pause ? rrtq_pkg::S_QSRCH_CMP : rrtq_pkg::S_DONE;
            rrtq_pkg::S_QSRCH_CMP:
                state_next = st.pause_id_match ? rrtq_pkg::S_QDROP_RD : rrtq_pkg::S_QSRCH_RD;
            rrtq_pkg::S_QDROP_RD:
                state_next = st.k1_lt_pause ? rrtq_pkg::S_QDROP_WR : rrtq_pkg::S_DONE;
            rrtq_pkg::S_QDROP_WR:
                state_next = rrtq_pkg::S_QDROP_RD;
            rrtq_pkg::S_PICK_FIN:
                state_next = rrtq_pkg::S_DONE;
            rrtq_pkg::S_MOD:
                state_next = st.mod_ge ? rrtq_pkg::S_MOD : rrtq_pkg::S_RET_CMP;
            rrtq_pkg::S_RET_CMP:
                state_next = (st.run_match && st.leave) ? rrtq_pkg::S_RDROP_RD
                                                        : rrtq_pkg::S_DONE;
            rrtq_pkg::S_DONE:
                if (st.out_free) state_next = rrtq_pkg::S_IDLE;
            default:
                state_next = rrtq_pkg::S_IDLE;
        endcase
    end

    // outputs: micro-operation per state
    always_comb
    begin
        op       = rrtq_pkg::OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            rrtq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) op = rrtq_pkg::OP_LOAD;
            end
            rrtq_pkg::S_DISPATCH:
            begin
                unique case (st.act)
                    rrtq_pkg::ACT_ENQUEUE:
                        op = rrtq_pkg::OP_APPEND;
                    rrtq_pkg::ACT_PICK:
                        op = st.run_empty ? rrtq_pkg::OP_IDLE_PICK : rrtq_pkg::OP_PICK_RD;
                    rrtq_pkg::ACT_RETIRE:
                        op = (st.run_empty || !st.lpv) ? rrtq_pkg::OP_SET_NF
                                                       : rrtq_pkg::OP_MOD_LOAD;
                    default:
                        op = rrtq_pkg::OP_NONE;
                endcase
            end
            rrtq_pkg::S_RSRCH_RD:
                op = st.k_lt_run ? rrtq_pkg::OP_RUN_RD_K : rrtq_pkg::OP_SET_NF;
            rrtq_pkg::S_RSRCH_CMP:
                op = st.run_match ? rrtq_pkg::OP_NONE : rrtq_pkg::OP_K_INC;
            rrtq_pkg::S_RDROP_RD:
                op = st.k1_lt_run ? rrtq_pkg::OP_RUN_RD_K1 : rrtq_pkg::OP_RUN_FIN;
            rrtq_pkg::S_RDROP_WR:
                op = rrtq_pkg::OP_RUN_WR_K;
            rrtq_pkg::S_AFTER_DROP:
            begin
                if (st.act == rrtq_pkg::ACT_PAUSE)
                    op = st.pause_full ? rrtq_pkg::OP_SET_FULL : rrtq_pkg::OP_K_CLR;
            end
            rrtq_pkg::S_PSRCH_RD:
                op = st.k_lt_pause ? rrtq_pkg::OP_PS_RD_K : rrtq_pkg::OP_POS_K;
            rrtq_pkg::S_PSRCH_CMP:
                op = st.pause_time_gt ? rrtq_pkg::OP_POS_K : rrtq_pkg::OP_K_INC;
            rrtq_pkg::S_PSHIFT_RD:
                op = st.k_gt_pos ? rrtq_pkg::OP_PS_RD_KM1 : rrtq_pkg::OP_PS_INS;
            rrtq_pkg::S_PSHIFT_WR:
                op = rrtq_pkg::OP_PS_WR_K_DEC;
            rrtq_pkg::S_QSRCH_RD:
                op = st.k_lt_pause ? rrtq_pkg::OP_PS_RD_K : rrtq_pkg::OP_SET_NF;
            rrtq_pkg::S_QSRCH_CMP:
                op = st.pause_id_match ? rrtq_pkg::OP_NONE : rrtq_pkg::OP_K_INC;
            rrtq_pkg::S_QDROP_RD:
                op = st.k1_lt_pause ? rrtq_pkg::OP_PS_RD_K1 : rrtq_pkg::OP_PS_FIN;
            rrtq_pkg::S_QDROP_WR:
                op = rrtq_pkg::OP_PS_WR_K_INC;
            rrtq_pkg::S_PICK_FIN:
                op = rrtq_pkg::OP_PICK_FIN;
            rrtq_pkg::S_MOD:
                op = st.mod_ge ? rrtq_pkg::OP_MOD_SUB : rrtq_pkg::OP_RUN_RD_M;
            rrtq_pkg::S_RET_CMP:
                op = (st.run_match && st.leave) ? rrtq_pkg::OP_K_FROM_M : rrtq_pkg::OP_SET_NF;
            rrtq_pkg::S_DONE:
                if (st.out_free) op = rrtq_pkg::OP_OUT;
            default:
                op = rrtq_pkg::OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

>>> design/rrtq_dp.sv
// Datapath: list memories, fills, round-robin pointer and result register.
`default_nettype none
module rrtq_dp (
    input  wire                          clk,
    input  wire                          rst_n,
    input  rrtq_pkg::dp_op_t             op,
    output rrtq_pkg::dp_status_t         st,
    input  wire  [2:0]                   action,
    input  wire  [15:0]                  thread_id,
    input  wire  [31:0]                  wake_time,
    input  wire                          leave_request,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [1:0]                   status,
    output logic [15:0]                  picked_id,
    output logic                         idle,
    output logic [rrtq_pkg::COUNT_W-1:0] run_count,
    output logic [rrtq_pkg::COUNT_W-1:0] sleep_count
);

    localparam int RAW = rrtq_pkg::RUN_AW;
    localparam int PAW = rrtq_pkg::PAUSE_AW;
    localparam int RCW = rrtq_pkg::RUN_CW;
    localparam int PCW = rrtq_pkg::PAUSE_CW;
    localparam int IW  = rrtq_pkg::IDX_W;

    // memories
    logic [15:0] run_mem   [rrtq_pkg::RUN_DEPTH];
    logic [47:0] pause_mem [rrtq_pkg::PAUSE_DEPTH];

    // item and scratch registers
    logic [2:0]     act_reg;
    logic [15:0]    id_reg;
    logic [31:0]    wake_reg;
    logic           leave_reg;
    logic [IW-1:0]  k_reg;
    logic [PCW-1:0] pos_reg;
    logic [RAW-1:0] m_reg;
    logic [15:0]    rrd_reg;
    logic [47:0]    prd_reg;
    logic [1:0]     st_reg;
    logic [15:0]    pick_reg;
    logic           idle_reg;

    // control state
    logic [RCW-1:0] run_fill_reg;
    logic [PCW-1:0] pause_fill_reg;
    logic [RAW-1:0] ptr_reg;
    logic [RAW-1:0] last_pick_reg;
    logic           lpv_reg;
    logic           out_valid_reg;

    // memory port controls
    logic           run_we, run_re, ps_we, ps_re;
    logic [RAW-1:0] run_wa, run_ra;
    logic [15:0]    run_wd;
    logic [PAW-1:0] ps_wa, ps_ra;
    logic [47:0]    ps_wd;

    logic [IW-1:0]  k_inc, k_dec;
    logic [RCW-1:0] run_fill_dec;
    logic [RAW-1:0] ptr_after_drop, ptr_after_pick;

    assign k_inc        = k_reg + IW'(1);
    assign k_dec        = k_reg - IW'(1);
    assign run_fill_dec = run_fill_reg - RCW'(1);

    // pointer steps back one, wrapping to the new last entry
    assign ptr_after_drop = (run_fill_dec == '0) ? '0 :
                            (ptr_reg == '0) ? RAW'(run_fill_dec - RCW'(1)) :
                            ptr_reg - RAW'(1);
    assign ptr_after_pick = ((RCW'(ptr_reg) + RCW'(1)) == run_fill_reg) ? '0
                            : ptr_reg + RAW'(1);

    // status to controller
    always_comb
    begin
        st.act            = act_reg;
        st.leave          = leave_reg;
        st.run_empty      = (run_fill_reg == '0);
        st.pause_full     = (pause_fill_reg >= PCW'(rrtq_pkg::PAUSE_DEPTH));
        st.lpv            = lpv_reg;
        st.k_lt_run       = (k_reg < IW'(run_fill_reg));
        st.k1_lt_run      = (k_inc < IW'(run_fill_reg));
        st.k_lt_pause     = (k_reg < IW'(pause_fill_reg));
        st.k1_lt_pause    = (k_inc < IW'(pause_fill_reg));
        st.k_gt_pos       = (k_reg > IW'(pos_reg));
        st.run_match      = (rrd_reg == id_reg);
        st.pause_id_match = (prd_reg[47:32] == id_reg);
        st.pause_time_gt  = (prd_reg[31:0] > wake_reg);
        st.mod_ge         = (RCW'(m_reg) >= run_fill_reg);
        st.out_free       = !out_valid_reg || out_ready;
    end

    // memory port decode
    always_comb
    begin
        run_we = 1'b0;
        run_re = 1'b0;
        ps_we  = 1'b0;
        ps_re  = 1'b0;
        run_wa = k_reg[RAW-1:0];
        run_ra = k_reg[RAW-1:0];
        run_wd = rrd_reg;
        ps_wa  = k_reg[PAW-1:0];
        ps_ra  = k_reg[PAW-1:0];
        ps_wd  = prd_reg;
        unique case (op)
            rrtq_pkg::OP_APPEND:
            begin
                run_we = (run_fill_reg < RCW'(rrtq_pkg::RUN_DEPTH));
                run_wa = run_fill_reg[RAW-1:0];
                run_wd = id_reg;
            end
            rrtq_pkg::OP_PS_FIN:
            begin
                run_we = (run_fill_reg < RCW'(rrtq_pkg::RUN_DEPTH));
                run_wa = run_fill_reg[RAW-1:0];
                run_wd = id_reg;
            end
            rrtq_pkg::OP_RUN_RD_K:  run_re = 1'b1;
            rrtq_pkg::OP_RUN_RD_K1:
            begin
                run_re = 1'b1;
                run_ra = k_inc[RAW-1:0];
            end
            rrtq_pkg::OP_RUN_WR_K:  run_we = 1'b1;
            rrtq_pkg::OP_PICK_RD:
            begin
                run_re = 1'b1;
                run_ra = ptr_reg;
            end
            rrtq_pkg::OP_RUN_RD_M:
            begin
                run_re = 1'b1;
                run_ra = m_reg;
            end
            rrtq_pkg::OP_PS_RD_K:   ps_re = 1'b1;
            rrtq_pkg::OP_PS_RD_K1:
            begin
                ps_re = 1'b1;
                ps_ra = k_inc[PAW-1:0];
            end
            rrtq_pkg::OP_PS_RD_KM1:
            begin
                ps_re = 1'b1;
                ps_ra = k_dec[PAW-1:0];
            end
            rrtq_pkg::OP_PS_WR_K_INC, rrtq_pkg::OP_PS_WR_K_DEC:
                ps_we = 1'b1;
            rrtq_pkg::OP_PS_INS:
            begin
                ps_we = 1'b1;
                ps_wa = pos_reg[PAW-1:0];
                ps_wd = {id_reg, wake_reg};
            end
            default:
                run_we = 1'b0;
        endcase
    end

    // run list memory
    always_ff @(posedge clk)
    begin
        if (run_we)
            run_mem[run_wa] <= run_wd;
        if (run_re)
            rrd_reg <= run_mem[run_ra];
    end

    // pause list memory, id over wake time
    always_ff @(posedge clk)
    begin
        if (ps_we)
            pause_mem[ps_wa] <= ps_wd;
        if (ps_re)
            prd_reg <= pause_mem[ps_ra];
    end

    // item and scratch registers
    always_ff @(posedge clk)
    begin
        unique case (op)
            rrtq_pkg::OP_LOAD:
            begin
                act_reg   <= action;
                id_reg    <= thread_id;
                wake_reg  <= wake_time;
                leave_reg <= leave_request;
                k_reg     <= '0;
                st_reg    <= rrtq_pkg::ST_OK;
                pick_reg  <= '0;
                idle_reg  <= 1'b0;
            end
            rrtq_pkg::OP_APPEND, rrtq_pkg::OP_PS_FIN:
                if (run_fill_reg >= RCW'(rrtq_pkg::RUN_DEPTH))
                    st_reg <= rrtq_pkg::ST_FULL;
            rrtq_pkg::OP_SET_NF:      st_reg <= rrtq_pkg::ST_NOT_FOUND;
            rrtq_pkg::OP_SET_FULL:    st_reg <= rrtq_pkg::ST_FULL;
            rrtq_pkg::OP_K_INC, rrtq_pkg::OP_RUN_WR_K, rrtq_pkg::OP_PS_WR_K_INC:
                k_reg <= k_inc;
            rrtq_pkg::OP_PS_WR_K_DEC: k_reg <= k_dec;
            rrtq_pkg::OP_K_CLR:       k_reg <= '0;
            rrtq_pkg::OP_POS_K:
            begin
                pos_reg <= k_reg[PCW-1:0];
                k_reg   <= IW'(pause_fill_reg);
            end
            rrtq_pkg::OP_IDLE_PICK:   idle_reg <= 1'b1;
            rrtq_pkg::OP_PICK_FIN:    pick_reg <= rrd_reg;
            rrtq_pkg::OP_MOD_LOAD:    m_reg <= last_pick_reg;
            rrtq_pkg::OP_MOD_SUB:     m_reg <= m_reg - RAW'(run_fill_reg);
            rrtq_pkg::OP_K_FROM_M:    k_reg <= IW'(m_reg);
            default:                  k_reg <= k_reg;
        endcase
    end

    // fills, pointer, last pick and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_fill_reg   <= '0;
            pause_fill_reg <= '0;
            ptr_reg        <= '0;
            last_pick_reg  <= '0;
            lpv_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (op == rrtq_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (op)
                rrtq_pkg::OP_APPEND:
                    if (run_fill_reg < RCW'(rrtq_pkg::RUN_DEPTH))
                        run_fill_reg <= run_fill_reg + RCW'(1);
                rrtq_pkg::OP_PS_FIN:
                begin
                    pause_fill_reg <= pause_fill_reg - PCW'(1);
                    if (run_fill_reg < RCW'(rrtq_pkg::RUN_DEPTH))
                        run_fill_reg <= run_fill_reg + RCW'(1);
                end
                rrtq_pkg::OP_RUN_FIN:
                begin
                    run_fill_reg <= run_fill_dec;
                    ptr_reg      <= ptr_after_drop;
                end
                rrtq_pkg::OP_PS_INS:   pause_fill_reg <= pause_fill_reg + PCW'(1);
                rrtq_pkg::OP_IDLE_PICK: lpv_reg <= 1'b0;
                rrtq_pkg::OP_PICK_FIN:
                begin
                    last_pick_reg <= ptr_reg;
                    lpv_reg       <= 1'b1;
                    ptr_reg       <= ptr_after_pick;
                end
                default:               lpv_reg <= lpv_reg;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (op == rrtq_pkg::OP_OUT)
        begin
            status      <= st_reg;
            picked_id   <= pick_reg;
            idle        <= idle_reg;
            run_count   <= rrtq_pkg::COUNT_W'(run_fill_reg);
            sleep_count <= rrtq_pkg::COUNT_W'(pause_fill_reg);
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> design/round_robin_run_and_timed_pause_queue.sv
// Top level: round-robin run list with a wake-time sorted pause list.
//
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+-------------------
//  in      | action, thread_id, wake_time, leave_request     | in_valid/in_ready
//  out     | status, picked_id, idle, run_count, sleep_count | out_valid/out_ready
//
// One item at a time. Enqueue appends to the run list; dequeue searches the run list
// and shifts the entries after the match down; pause also inserts into the pause list
// by wake time; restart searches the pause list by id, shifts the entries after it
// down and appends to the run list; retire reduces the last pick by modulo subtraction
// and, with leave set, removes that entry if it holds the thread. Reset clears fills
// and pointer at once. A stalled result holds in the output register; the next item
// waits at the end of its own work for that register to free.
`default_nettype none
`include "round_robin_run_and_timed_pause_queue_defines.svh"
module round_robin_run_and_timed_pause_queue (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [2:0]                   action,
    input  wire  [15:0]                  thread_id,
    input  wire  [31:0]                  wake_time,
    input  wire                          leave_request,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [1:0]                   status,
    output logic [15:0]                  picked_id,
    output logic                         idle,
    output logic [rrtq_pkg::COUNT_W-1:0] run_count,
    output logic [rrtq_pkg::COUNT_W-1:0] sleep_count
);

    rrtq_pkg::dp_op_t     op;
    rrtq_pkg::dp_status_t st;

    // sequencer
    rrtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .op       (op)
    );

    // lists and result register
    rrtq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .st            (st),
        .action        (action),
        .thread_id     (thread_id),
        .wake_time     (wake_time),
        .leave_request (leave_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .picked_id     (picked_id),
        .idle          (idle),
        .run_count     (run_count),
        .sleep_count   (sleep_count)
    );

    // checks
    `RRTQ_ASSERT_NOW(a_idle_no_pick, clk, rst_n, out_valid && idle, picked_id == 16'd0 && status == rrtq_pkg::ST_OK)
    `RRTQ_ASSERT_NOW(a_run_bound, clk, rst_n, out_valid, run_count <= rrtq_pkg::COUNT_W'(rrtq_pkg::RUN_DEPTH) && sleep_count <= rrtq_pkg::COUNT_W'(rrtq_pkg::PAUSE_DEPTH))
    `RRTQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire
